### rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock edge outside reset
`define BDC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// implication whose consequent is checked in the cycle after the antecedent
`define BDC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/core/bdc_pkg.sv
// types and constants of the baud divisor calculator
// no dependencies
`default_nettype none
package bdc_pkg;

  localparam int unsigned NumCells = 17;
  localparam int unsigned RemW     = 37;
  localparam int unsigned DenW     = 53;
  localparam int unsigned QuoW     = 17;
  localparam int unsigned ProdW    = 61;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusInval  = 2'd1;
  localparam logic [1:0] StatusUnach  = 2'd2;

  localparam logic [1:0] ModeAsync    = 2'd0;
  localparam logic [1:0] ModeSyncMst  = 2'd1;
  localparam logic [1:0] ModeSyncSlv  = 2'd2;

  localparam logic [0:0] CfgClock     = 1'd0;
  localparam logic [0:0] CfgTol       = 1'd1;

  localparam logic [31:0] ClockReset  = 32'd16000000;
  localparam logic [6:0]  TolReset    = 7'd2;

  typedef struct packed {
    logic [RemW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
    logic            ovf;
  } div_lane_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] baud;
    logic [1:0]  mode;
    div_lane_t   lane_a;
    div_lane_t   lane_b;
  } cell_data_t;

endpackage
`default_nettype wire

### rtl/core/bdc_if.sv
// valid/ready channels of the baud divisor calculator
// no dependencies
`default_nettype none
interface bdc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] baud_rate;
  logic [1:0]  port_mode;
  modport source (output valid, baud_rate, port_mode, input ready);
  modport sink (input valid, baud_rate, port_mode, output ready);
endinterface

interface bdc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] divisor;
  logic        double_speed;
  logic [1:0]  status;
  modport source (output valid, divisor, double_speed, status, input ready);
  modport sink (input valid, divisor, double_speed, status, output ready);
endinterface
`default_nettype wire

### rtl/core/bdc_div_cell.sv
// one restoring division step for both factor lanes
// depends on bdc_pkg
`default_nettype none
module bdc_div_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire bdc_pkg::cell_data_t data_i,
  output bdc_pkg::cell_data_t     data_o
);
  import bdc_pkg::*;

  cell_data_t data_d, data_q;
  logic       valid_q;

  function automatic div_lane_t step(input div_lane_t l);
    div_lane_t r;
    logic      ge;
    ge    = {(DenW-RemW)'(0), l.rem} >= l.den;
    r     = l;
    r.rem = ge ? l.rem - l.den[RemW-1:0] : l.rem;
    r.den = l.den >> 1;
    r.quo = {l.quo[QuoW-2:0], ge};
    return r;
  endfunction

  always_comb begin
    data_d        = data_i;
    data_d.lane_a = step(data_i.lane_a);
    data_d.lane_b = step(data_i.lane_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= data_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    data_o       = data_q;
    data_o.valid = valid_q;
  end
endmodule
`default_nettype wire

### rtl/core/bdc_tol_check.sv
// tolerance products, compare and result selection
// depends on bdc_pkg
`default_nettype none
`include "assert_macros.svh"
module bdc_tol_check (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [31:0]         clock_hz_i,
  input  wire logic [6:0]          tol_i,
  input  wire bdc_pkg::cell_data_t data_i,
  output logic                     valid_o,
  output logic [15:0]              divisor_o,
  output logic                     double_speed_o,
  output logic [1:0]               status_o
);
  import bdc_pkg::*;

  // stage 1
  logic             v1_q;
  logic [31:0]      baud1_q;
  logic [1:0]       mode1_q;
  logic [QuoW-1:0]  qa1_q, qb1_q;
  logic             bada1_q, badb1_q;
  logic [20:0]      spa1_q, spb1_q;
  logic [39:0]      bth1_q, btl1_q;
  // stage 2
  logic             v2_q;
  logic [31:0]      baud2_q;
  logic [1:0]       mode2_q;
  logic [QuoW-1:0]  qa2_q, qb2_q;
  logic             bada2_q, badb2_q;
  logic [ProdW-1:0] hia2_q, loa2_q, hib2_q, lob2_q;
  // output
  logic             v3_q;
  logic [15:0]      div3_q;
  logic             dbl3_q;
  logic [1:0]       st3_q;

  logic [20:0]      spa1_d, spb1_d;
  logic [7:0]       tol_hi;
  logic [6:0]       tol_lo;
  logic [38:0]      sclk;
  logic             oka, okb;
  logic [15:0]      div3_d;
  logic             dbl3_d;
  logic [1:0]       st3_d;

  function automatic logic bad_quo(input div_lane_t l);
    return l.ovf || (l.quo == '0) || (l.quo > QuoW'(65536));
  endfunction

  assign spa1_d = (data_i.mode == ModeAsync) ? {data_i.lane_a.quo, 4'b0}
                                             : {3'b0, data_i.lane_a.quo, 1'b0};
  assign spb1_d = {1'b0, data_i.lane_b.quo, 3'b0};
  assign tol_hi = 8'(tol_i) + 8'd100;
  assign tol_lo = 7'd100 - tol_i;
  assign sclk   = 39'(clock_hz_i) * 39'd100;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= data_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      baud1_q <= data_i.baud;
      mode1_q <= data_i.mode;
      qa1_q   <= data_i.lane_a.quo;
      qb1_q   <= data_i.lane_b.quo;
      bada1_q <= bad_quo(data_i.lane_a);
      badb1_q <= bad_quo(data_i.lane_b);
      spa1_q  <= spa1_d;
      spb1_q  <= spb1_d;
      bth1_q  <= 40'(data_i.baud) * 40'(tol_hi);
      btl1_q  <= (tol_i >= 7'd100) ? 40'd0 : 40'(data_i.baud) * 40'(tol_lo);

      baud2_q <= baud1_q;
      mode2_q <= mode1_q;
      qa2_q   <= qa1_q;
      qb2_q   <= qb1_q;
      bada2_q <= bada1_q;
      badb2_q <= badb1_q;
      hia2_q  <= ProdW'(spa1_q) * ProdW'(bth1_q);
      loa2_q  <= ProdW'(spa1_q) * ProdW'(btl1_q);
      hib2_q  <= ProdW'(spb1_q) * ProdW'(bth1_q);
      lob2_q  <= ProdW'(spb1_q) * ProdW'(btl1_q);

      div3_q  <= div3_d;
      dbl3_q  <= dbl3_d;
      st3_q   <= st3_d;
    end
  end

  always_comb begin
    oka    = !bada2_q && !(ProdW'(sclk) > hia2_q) && !(ProdW'(sclk) < loa2_q);
    okb    = !badb2_q && !(ProdW'(sclk) > hib2_q) && !(ProdW'(sclk) < lob2_q);
    div3_d = '0;
    dbl3_d = 1'b0;
    st3_d  = StatusOk;
    if (baud2_q == '0 || !(mode2_q == ModeAsync || mode2_q == ModeSyncMst ||
        mode2_q == ModeSyncSlv)) begin
      st3_d = StatusInval;
    end else if (oka) begin
      div3_d = 16'(qa2_q - 17'd1);
    end else if (mode2_q == ModeAsync && okb) begin
      div3_d = 16'(qb2_q - 17'd1);
      dbl3_d = 1'b1;
    end else begin
      st3_d = StatusUnach;
    end
  end

  assign valid_o        = v3_q;
  assign divisor_o      = div3_q;
  assign double_speed_o = dbl3_q;
  assign status_o       = st3_q;

  `BDC_ASSERT(a_fail_zero, clk_i, rst_ni,
    !(v3_q && st3_q != StatusOk) || (div3_q == '0 && !dbl3_q))
  `BDC_ASSERT(a_dbl_ok, clk_i, rst_ni, !(v3_q && dbl3_q) || (st3_q == StatusOk))
  `BDC_ASSERT_NEXT(a_hold, clk_i, rst_ni, !en_i && v3_q, v3_q && $stable(st3_q))
endmodule
`default_nettype wire

### rtl/core/baud_divisor_calc.sv
// baud divisor calculator top level
// depends on bdc_pkg, bdc_if, bdc_div_cell, bdc_tol_check
//
// usage: write clock_hz (index 0) and tolerance_pct (index 1) through the
// cfg port while no request is in flight. requests enter on in_if as
// baud_rate and port_mode transactions, one result leaves on out_if per
// request with divisor, double_speed and status.
// the pipeline is 17 division cells, two product stages and the output
// register. throughput is one transaction per cycle unless the receiver
// stalls; the chain of division cells and the pipelined multipliers
// accept a new request every cycle while out_if is not stalled.
// reset clears all valid flags and loads clock_hz = 16000000 and
// tolerance_pct = 2.
// when the receiver stalls, the whole pipeline holds and in_if.ready
// drops until the output transaction is taken.
`default_nettype none
`include "assert_macros.svh"
module baud_divisor_calc (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  bdc_in_if.sink           in_if,
  bdc_out_if.source        out_if
);
  import bdc_pkg::*;

  logic [31:0] clock_q;
  logic [6:0]  tol_q;
  logic        en;
  logic        out_valid;
  cell_data_t  chain [NumCells+1];
  logic [35:0] den_a, den_b;
  logic [RemW-1:0] num_a, num_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q <= ClockReset;
      tol_q   <= TolReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClock: clock_q <= cfg_data_i;
        CfgTol:   tol_q   <= cfg_data_i[6:0];
        default:  ;
      endcase
    end
  end

  assign en          = !out_valid || out_if.ready;
  assign in_if.ready = en;

  always_comb begin
    if (in_if.port_mode == ModeAsync) begin
      den_a = {in_if.baud_rate, 4'b0};
      num_a = RemW'(clock_q) + RemW'({in_if.baud_rate, 3'b0});
    end else begin
      den_a = {3'b0, in_if.baud_rate, 1'b0};
      num_a = RemW'(clock_q) + RemW'(in_if.baud_rate);
    end
    den_b = {1'b0, in_if.baud_rate, 3'b0};
    num_b = RemW'(clock_q) + RemW'({in_if.baud_rate, 2'b0});

    chain[0].valid      = in_if.valid;
    chain[0].baud       = in_if.baud_rate;
    chain[0].mode       = in_if.port_mode;
    chain[0].lane_a.rem = num_a;
    chain[0].lane_a.den = {1'b0, den_a, 16'b0};
    chain[0].lane_a.quo = '0;
    chain[0].lane_a.ovf = {17'b0, num_a} >= {1'b0, den_a, 17'b0};
    chain[0].lane_b.rem = num_b;
    chain[0].lane_b.den = {1'b0, den_b, 16'b0};
    chain[0].lane_b.quo = '0;
    chain[0].lane_b.ovf = {17'b0, num_b} >= {1'b0, den_b, 17'b0};
  end

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    bdc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .data_i (chain[k]),
      .data_o (chain[k+1])
    );
  end

  bdc_tol_check u_tol (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .clock_hz_i     (clock_q),
    .tol_i          (tol_q),
    .data_i         (chain[NumCells]),
    .valid_o        (out_valid),
    .divisor_o      (out_if.divisor),
    .double_speed_o (out_if.double_speed),
    .status_o       (out_if.status)
  );

  assign out_if.valid = out_valid;

  `BDC_ASSERT(a_stall_blocks, clk_i, rst_ni, !(out_valid && !out_if.ready) || !in_if.ready)
  `BDC_ASSERT_NEXT(a_drain, clk_i, rst_ni, out_valid && out_if.ready && !chain[NumCells].valid
    && !u_tol.v1_q && !u_tol.v2_q, !out_valid)
  `BDC_ASSERT(a_status_range, clk_i, rst_ni, !out_valid || out_if.status != 2'd3)
endmodule
`default_nettype wire
